// File: rtl/rtsq_pkg.sv
// Package for the ready time sorted queue: sizes, entry layout, command and
// status codes, and the controller/datapath interface structs.
// No dependencies.
package rtsq_pkg;

   localparam int DEPTH   = 16;
   localparam int AddrW   = $clog2(DEPTH);
   localparam int CountW  = $clog2(DEPTH + 1);
   localparam int ThreadW = 8;
   localparam int TimeW   = 32;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DEQUEUE = 2'd2,
      CMD_PEEK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [ThreadW-1:0] thread_id;
      logic [TimeW-1:0]   ready_time;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_CHECK,
      ST_TAIL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic latch;
      logic step;
      logic tail;
      logic set_full;
      logic set_empty;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    last;
   } sts_type;

endpackage

// File: rtl/rtsq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rtsq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rtsq_ctrl.sv
// Controller state machine for the ready time sorted queue.
// Depends on rtsq_pkg.
module rtsq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rtsq_pkg::sts_type sts,
   output rtsq_pkg::ctl_type ctl,
   output logic             busy,
   output logic             strobe
);

   rtsq_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtsq_pkg::ST_IDLE: begin
            if (start) begin
               state_in = rtsq_pkg::ST_DISPATCH;
            end
         end
         rtsq_pkg::ST_DISPATCH: begin
            unique case (sts.cmd)
               rtsq_pkg::CMD_APPEND: begin
                  state_in = sts.full ? rtsq_pkg::ST_DONE : rtsq_pkg::ST_TAIL;
               end
               rtsq_pkg::CMD_INSERT: begin
                  priority if (sts.full) begin
                     state_in = rtsq_pkg::ST_DONE;
                  end else if (sts.empty) begin
                     state_in = rtsq_pkg::ST_TAIL;
                  end else begin
                     state_in = rtsq_pkg::ST_READ;
                  end
               end
               rtsq_pkg::CMD_DEQUEUE, rtsq_pkg::CMD_PEEK: begin
                  state_in = sts.empty ? rtsq_pkg::ST_DONE : rtsq_pkg::ST_READ;
               end
               default: state_in = rtsq_pkg::ST_DONE;
            endcase
         end
         rtsq_pkg::ST_READ: state_in = rtsq_pkg::ST_CHECK;
         rtsq_pkg::ST_CHECK: begin
            priority if (sts.cmd == rtsq_pkg::CMD_PEEK) begin
               state_in = rtsq_pkg::ST_DONE;
            end else if (!sts.last) begin
               state_in = rtsq_pkg::ST_READ;
            end else if (sts.cmd == rtsq_pkg::CMD_INSERT) begin
               state_in = rtsq_pkg::ST_TAIL;
            end else begin
               state_in = rtsq_pkg::ST_DONE;
            end
         end
         rtsq_pkg::ST_TAIL: state_in = rtsq_pkg::ST_DONE;
         rtsq_pkg::ST_DONE: state_in = rtsq_pkg::ST_IDLE;
         default: state_in = rtsq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl    = '0;
      busy   = 1'b1;
      strobe = 1'b0;
      unique case (state_ff)
         rtsq_pkg::ST_IDLE: begin
            busy      = 1'b0;
            ctl.latch = start;
         end
         rtsq_pkg::ST_DISPATCH: begin
            if (sts.cmd == rtsq_pkg::CMD_APPEND || sts.cmd == rtsq_pkg::CMD_INSERT) begin
               ctl.set_full = sts.full;
            end else begin
               ctl.set_empty = sts.empty;
            end
         end
         rtsq_pkg::ST_READ: begin
         end
         rtsq_pkg::ST_CHECK: ctl.step = 1'b1;
         rtsq_pkg::ST_TAIL:  ctl.tail = 1'b1;
         rtsq_pkg::ST_DONE:  strobe = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtsq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/rtsq_datapath.sv
// Datapath of the ready time sorted queue: entry RAM, scan index, carried
// entry, fill count and result registers. Depends on rtsq_pkg and rtsq_ram.
module rtsq_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  rtsq_pkg::ctl_type               ctl,
   output rtsq_pkg::sts_type               sts,
   input  logic [1:0]                      req_command,
   input  logic [rtsq_pkg::ThreadW-1:0]    req_thread_id,
   input  logic [rtsq_pkg::TimeW-1:0]      req_ready_time,
   output logic [rtsq_pkg::ThreadW-1:0]    rsp_head_thread,
   output logic [rtsq_pkg::TimeW-1:0]      rsp_head_time,
   output logic                            rsp_head_valid,
   output logic [rtsq_pkg::CountW-1:0]     rsp_entry_count,
   output logic [1:0]                      rsp_status
);

   rtsq_pkg::cmd_type              cmd_ff, cmd_in;
   rtsq_pkg::entry_type            carry_ff, carry_in;
   rtsq_pkg::entry_type            head_ff, head_in;
   rtsq_pkg::status_type           status_ff, status_in;
   logic                           head_valid_ff, head_valid_in;
   logic                           found_ff, found_in;
   logic [rtsq_pkg::CountW-1:0]    idx_ff, idx_in;
   logic [rtsq_pkg::CountW-1:0]    fill_ff, fill_in;

   logic                           wr_en;
   logic [rtsq_pkg::AddrW-1:0]     wr_addr;
   rtsq_pkg::entry_type            wr_data;
   rtsq_pkg::entry_type            rd_data;
   logic [rtsq_pkg::EntryW-1:0]    rd_bits;
   logic [rtsq_pkg::AddrW-1:0]     idx_prev;

   rtsq_ram #(
      .Width (rtsq_pkg::EntryW),
      .Depth (rtsq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[rtsq_pkg::AddrW-1:0]),
      .rd_data (rd_bits)
   );

   assign rd_data  = rtsq_pkg::entry_type'(rd_bits);
   assign idx_prev = idx_ff[rtsq_pkg::AddrW-1:0] - rtsq_pkg::AddrW'(1);

   assign sts.cmd   = cmd_ff;
   assign sts.full  = (fill_ff == rtsq_pkg::CountW'(rtsq_pkg::DEPTH));
   assign sts.empty = (fill_ff == '0);
   assign sts.last  = (idx_ff + rtsq_pkg::CountW'(1) == fill_ff);

   always_comb begin
      cmd_in        = cmd_ff;
      carry_in      = carry_ff;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      wr_en         = 1'b0;
      wr_addr       = fill_ff[rtsq_pkg::AddrW-1:0];
      wr_data       = carry_ff;

      if (ctl.latch) begin
         cmd_in                = rtsq_pkg::cmd_type'(req_command);
         carry_in.thread_id    = req_thread_id;
         carry_in.ready_time   = req_ready_time;
         head_in               = '0;
         head_valid_in         = 1'b0;
         status_in             = rtsq_pkg::STATUS_OK;
         found_in              = 1'b0;
         idx_in                = '0;
      end

      if (ctl.set_full) begin
         status_in = rtsq_pkg::STATUS_FULL;
      end
      if (ctl.set_empty) begin
         status_in = rtsq_pkg::STATUS_EMPTY;
      end

      if (ctl.step) begin
         idx_in = idx_ff + rtsq_pkg::CountW'(1);
         unique case (cmd_ff)
            rtsq_pkg::CMD_INSERT: begin
               if (found_ff || (carry_ff.ready_time < rd_data.ready_time)) begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_ff[rtsq_pkg::AddrW-1:0];
                  wr_data  = carry_ff;
                  carry_in = rd_data;
                  found_in = 1'b1;
               end
            end
            rtsq_pkg::CMD_DEQUEUE: begin
               if (idx_ff == '0) begin
                  head_in       = rd_data;
                  head_valid_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = idx_prev;
                  wr_data = rd_data;
               end
               if (sts.last) begin
                  fill_in = fill_ff - rtsq_pkg::CountW'(1);
               end
            end
            rtsq_pkg::CMD_PEEK: begin
               head_in       = rd_data;
               head_valid_in = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (ctl.tail) begin
         wr_en   = 1'b1;
         wr_addr = fill_ff[rtsq_pkg::AddrW-1:0];
         wr_data = carry_ff;
         fill_in = fill_ff + rtsq_pkg::CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         found_ff <= found_in;
      end
      cmd_ff        <= cmd_in;
      carry_ff      <= carry_in;
      head_ff       <= head_in;
      head_valid_ff <= head_valid_in;
      status_ff     <= status_in;
   end

   assign rsp_head_thread = head_ff.thread_id;
   assign rsp_head_time   = head_ff.ready_time;
   assign rsp_head_valid  = head_valid_ff;
   assign rsp_entry_count = fill_ff;
   assign rsp_status      = status_ff;

endmodule

// File: rtl/ready_time_sorted_queue.sv
// Top level of the ready time sorted queue: joins the controller and datapath.
// Depends on rtsq_pkg, rtsq_ctrl and rtsq_datapath.
//
// Usage: drive req_command, req_thread_id and req_ready_time and raise start;
// the item is taken at the clock edge where start is high and busy is low.
// busy stays high until the result has been shown. The result is marked on the
// rsp_ ports by rsp_strobe, which is high for exactly one cycle; the receiver
// cannot stall it. Every item gives one result, which carries the entry count
// after the command. busy falls in the cycle after the strobe, so the next item
// can be taken at the edge that ends that cycle. Because the entry RAM has a
// single read port, sorted insert and dequeue walk the entries one at a time,
// each with a read step and then a compare and move step.
// Synchronous reset empties the queue and returns the controller to idle;
// the RAM contents are not cleared.
module ready_time_sorted_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_command,
   input  logic [rtsq_pkg::ThreadW-1:0] req_thread_id,
   input  logic [rtsq_pkg::TimeW-1:0]   req_ready_time,
   output logic                         rsp_strobe,
   output logic [rtsq_pkg::ThreadW-1:0] rsp_head_thread,
   output logic [rtsq_pkg::TimeW-1:0]   rsp_head_time,
   output logic                         rsp_head_valid,
   output logic [rtsq_pkg::CountW-1:0]  rsp_entry_count,
   output logic [1:0]                   rsp_status
);

   rtsq_pkg::ctl_type ctl;
   rtsq_pkg::sts_type sts;

   rtsq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .sts    (sts),
      .ctl    (ctl),
      .busy   (busy),
      .strobe (rsp_strobe)
   );

   rtsq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_command     (req_command),
      .req_thread_id   (req_thread_id),
      .req_ready_time  (req_ready_time),
      .rsp_head_thread (rsp_head_thread),
      .rsp_head_time   (rsp_head_time),
      .rsp_head_valid  (rsp_head_valid),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

endmodule

// File: rtl/rtsq_checker.sv
// Port-level checker for the ready time sorted queue, bound to the top level.
// Depends on rtsq_pkg and ready_time_sorted_queue.
module rtsq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [1:0]                   req_command,
   input logic [rtsq_pkg::ThreadW-1:0] req_thread_id,
   input logic [rtsq_pkg::TimeW-1:0]   req_ready_time,
   input logic                         rsp_strobe,
   input logic [rtsq_pkg::ThreadW-1:0] rsp_head_thread,
   input logic [rtsq_pkg::TimeW-1:0]   rsp_head_time,
   input logic                         rsp_head_valid,
   input logic [rtsq_pkg::CountW-1:0]  rsp_entry_count,
   input logic [1:0]                   rsp_status
);

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an item was accepted");

   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy ##1 !busy && !rsp_strobe)
      else $error("result strobe outside a busy command or longer than one cycle");

   a_head_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_head_valid |-> rsp_head_thread == '0 && rsp_head_time == '0)
      else $error("head fields not zero without a head entry");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == rtsq_pkg::STATUS_FULL |->
         rsp_entry_count == rtsq_pkg::CountW'(rtsq_pkg::DEPTH) && !rsp_head_valid)
      else $error("full status with a count below the depth");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == rtsq_pkg::STATUS_EMPTY |->
         rsp_entry_count == '0 && !rsp_head_valid)
      else $error("empty status with entries held");

endmodule

bind ready_time_sorted_queue rtsq_checker u_rtsq_checker (.*);
